// ===== hdl/vfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume fade ramp package
// Shared widths, event codes, register indexes, reset values and the
// structures passed between the controller and its serial ramp unit.
// ----------------------------------------------------------------------------
package vfr_pkg;

   // Field widths.
   localparam int LEVEL_W = 16;
   localparam int FRAC_W  = 17;
   localparam int MS_W    = 16;
   localparam int OP_W    = 3;
   localparam int CSR_W   = 2;

   // A ramp fraction of exactly 1.0 in Q1.16.
   localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {LEVEL_W{1'b0}}};

   // Event codes.
   localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
   localparam logic [OP_W-1:0] OP_SET_MUTE = 3'd1;
   localparam logic [OP_W-1:0] OP_FADE_OUT = 3'd2;
   localparam logic [OP_W-1:0] OP_START    = 3'd3;
   localparam logic [OP_W-1:0] OP_SHUTDOWN = 3'd4;

   // Register indexes.
   localparam logic [CSR_W-1:0] CSR_MENU_VOLUME    = 2'd0;
   localparam logic [CSR_W-1:0] CSR_MUTE_FADE_MS   = 2'd1;
   localparam logic [CSR_W-1:0] CSR_UNMUTE_FADE_MS = 2'd2;
   localparam logic [CSR_W-1:0] CSR_START_FADE_MS  = 2'd3;

   // Register reset values.
   localparam logic [LEVEL_W-1:0] RST_MENU_VOLUME    = 16'd36045;
   localparam logic [MS_W-1:0]    RST_MUTE_FADE_MS   = 16'd250;
   localparam logic [MS_W-1:0]    RST_UNMUTE_FADE_MS = 16'd50;
   localparam logic [MS_W-1:0]    RST_START_FADE_MS  = 16'd1500;

   // Operands of one ramp step.
   typedef struct packed {
      logic [MS_W-1:0]    elapsed;
      logic [MS_W-1:0]    duration;
      logic [FRAC_W-1:0]  fraction;
      logic [LEVEL_W-1:0] start_level;
      logic [LEVEL_W-1:0] target_level;
   } ramp_args_type;

   // Outcome of one ramp step.
   typedef struct packed {
      logic [LEVEL_W-1:0] gain;
      logic [FRAC_W-1:0]  fraction;
      logic               expired;
   } ramp_result_type;

endpackage

// ===== hdl/vfr_ramp_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial ramp step unit
// Advances the ramp fraction by elapsed/duration with a two-bit-per-cycle
// restoring divider, saturates it at 1.0, then interpolates the gain with a
// two-bit-per-cycle shift-and-add multiplier.
// ----------------------------------------------------------------------------
module vfr_ramp_step (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  vfr_pkg::ramp_args_type   args,
   output logic                     done,
   output vfr_pkg::ramp_result_type result
);
   import vfr_pkg::*;

   localparam int DIGIT_W = 2;
   localparam int STEPS   = LEVEL_W / DIGIT_W;
   localparam int CNT_W   = $clog2(STEPS);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DIV  = 5'b00010,
      S_SUM  = 5'b00100,
      S_MUL  = 5'b01000,
      S_DONE = 5'b10000
   } step_state_type;

   step_state_type     state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [MS_W-1:0]    dur_ff, dur_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [LEVEL_W-1:0] base_ff, base_in;
   logic               rising_ff, rising_in;
   logic [LEVEL_W-1:0] diff_ff, diff_in;
   logic [MS_W-1:0]    rem_ff, rem_in;
   logic [LEVEL_W-1:0] quo_ff, quo_in;
   logic               sat_ff, sat_in;
   logic               expired_ff, expired_in;
   logic [LEVEL_W-1:0] hi_ff, hi_in;
   logic [LEVEL_W-1:0] lo_ff, lo_in;

   logic [MS_W:0]      div_t1, div_t2, div_r1, div_r2;
   logic               div_ge1, div_ge2;
   logic [FRAC_W:0]    frac_sum;
   logic [FRAC_W-1:0]  frac_next;
   logic [LEVEL_W+1:0] mul_sum;
   logic [LEVEL_W-1:0] prod;
   logic               elapsed_ge;

   // Two restoring division steps per cycle; the remainder stays below the divisor.
   always_comb begin
      div_t1  = {rem_ff, 1'b0};
      div_ge1 = (div_t1 >= {1'b0, dur_ff});
      div_r1  = div_ge1 ? (div_t1 - {1'b0, dur_ff}) : div_t1;
      div_t2  = {div_r1[MS_W-1:0], 1'b0};
      div_ge2 = (div_t2 >= {1'b0, dur_ff});
      div_r2  = div_ge2 ? (div_t2 - {1'b0, dur_ff}) : div_t2;
   end

   // Fraction update with saturation at 1.0.
   always_comb begin
      frac_sum   = {1'b0, frac_ff} + {2'b00, quo_ff};
      frac_next  = frac_ff;
      expired_in = expired_ff;
      if (state_ff == S_SUM) begin
         expired_in = 1'b0;
         if (dur_ff != '0) begin
            if (sat_ff || (frac_sum >= {1'b0, FRAC_ONE})) begin
               frac_next  = FRAC_ONE;
               expired_in = 1'b1;
            end else begin
               frac_next = frac_sum[FRAC_W-1:0];
            end
         end
      end
   end

   // One multiplier digit: add zero, one, two or three times the level span.
   always_comb begin
      mul_sum = {2'b00, hi_ff}
              + (lo_ff[0] ? {2'b00, diff_ff} : '0)
              + (lo_ff[1] ? {1'b0, diff_ff, 1'b0} : '0);
   end

   assign elapsed_ge = (args.elapsed >= args.duration);

   // Sequencer: load, divide (skipped when the duration is zero or already elapsed), add, multiply, report.
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      dur_in    = dur_ff;
      frac_in   = frac_ff;
      base_in   = base_ff;
      rising_in = rising_ff;
      diff_in   = diff_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      sat_in    = sat_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               dur_in    = args.duration;
               frac_in   = args.fraction;
               base_in   = args.start_level;
               rising_in = (args.target_level >= args.start_level);
               diff_in   = (args.target_level >= args.start_level) ?
                           (args.target_level - args.start_level) :
                           (args.start_level - args.target_level);
               rem_in    = args.elapsed;
               quo_in    = '0;
               cnt_in    = '0;
               sat_in    = (args.duration != '0) && elapsed_ge;
               if ((args.duration != '0) && !elapsed_ge) begin
                  state_in = S_DIV;
               end else begin
                  state_in = S_SUM;
               end
            end
         end
         S_DIV: begin
            rem_in = div_r2[MS_W-1:0];
            quo_in = {quo_ff[LEVEL_W-DIGIT_W-1:0], div_ge1, div_ge2};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            frac_in  = frac_next;
            hi_in    = '0;
            lo_in    = frac_next[LEVEL_W-1:0];
            cnt_in   = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            hi_in  = mul_sum[LEVEL_W+1:DIGIT_W];
            lo_in  = {mul_sum[DIGIT_W-1:0], lo_ff[LEVEL_W-1:DIGIT_W]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEPS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      dur_ff     <= dur_in;
      frac_ff    <= frac_in;
      base_ff    <= base_in;
      rising_ff  <= rising_in;
      diff_ff    <= diff_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      sat_ff     <= sat_in;
      expired_ff <= expired_in;
      hi_ff      <= hi_in;
      lo_ff      <= lo_in;
   end

   // At a full fraction the span is taken whole; otherwise the product's top half.
   assign prod            = frac_ff[LEVEL_W] ? diff_ff : hi_ff;
   assign done            = (state_ff == S_DONE);
   assign result.gain     = rising_ff ? (base_ff + prod) : (base_ff - prod);
   assign result.fraction = frac_ff;
   assign result.expired  = expired_ff;

endmodule

// ===== hdl/volume_fade_ramp_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Volume fade ramp controller
// Gain ramp controller for one music stream: ticks advance a linear ramp,
// mute, fade out, start and shutdown events set up ramps and stream state.
// ----------------------------------------------------------------------------
// Usage:
// Events enter on the req_ channel and each yields exactly one beat on the
// rsp_ channel with the gain and stream status after that event. A beat is
// taken when valid is high and stall is low. Registers are written on the
// csr_ channel (index 0 menu volume, 1 mute fade, 2 unmute fade, 3 start
// fade); csr_ready is always high, writes belong in idle periods.
// Sequence: a tick with an open stream passes through the radix-4 divider,
// an add step and the radix-4 multiplier of the ramp unit before its result
// is captured; the divider is skipped when the ramp expires or has no
// duration. Any other event goes straight to the finish state, from which
// its result moves into the output register.
// One event is in flight at a time; req_stall is high until its result
// has moved into the output register, which holds it while rsp_stall is
// high. A new event is taken while that result still waits.
// Reset clears all stream state and loads the register defaults.
// ----------------------------------------------------------------------------
module volume_fade_ramp_controller_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [vfr_pkg::OP_W-1:0]     req_op,
   input  logic [vfr_pkg::MS_W-1:0]     req_elapsed_ms,
   input  logic                         req_mute_on,
   input  logic [vfr_pkg::MS_W-1:0]     req_fade_ms,
   input  logic                         req_load_ok,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [vfr_pkg::LEVEL_W-1:0]  rsp_gain,
   output logic                         rsp_gain_changed,
   output logic                         rsp_playing_now,
   output logic                         rsp_stop_request,
   output logic                         rsp_is_silent,
   output logic                         rsp_start_ok,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [vfr_pkg::CSR_W-1:0]    csr_index,
   input  logic [vfr_pkg::LEVEL_W-1:0]  csr_wdata
);
   import vfr_pkg::*;

   typedef enum logic [2:0] {
      T_IDLE   = 3'b001,
      T_ARITH  = 3'b010,
      T_FINISH = 3'b100
   } ctrl_state_type;

   ctrl_state_type     state_ff, state_in;

   logic [LEVEL_W-1:0] menu_volume_ff, menu_volume_in;
   logic [MS_W-1:0]    mute_fade_ff, mute_fade_in;
   logic [MS_W-1:0]    unmute_fade_ff, unmute_fade_in;
   logic [MS_W-1:0]    start_fade_ff, start_fade_in;

   logic               have_stream_ff, have_stream_in;
   logic               playing_ff, playing_in;
   logic               muted_ff, muted_in;
   logic               stopping_ff, stopping_in;
   logic [LEVEL_W-1:0] target_ff, target_in;
   logic [LEVEL_W-1:0] current_ff, current_in;
   logic [LEVEL_W-1:0] start_level_ff, start_level_in;
   logic [MS_W-1:0]    duration_ff, duration_in;
   logic [FRAC_W-1:0]  fraction_ff, fraction_in;
   logic               changed_ff, changed_in;
   logic               stop_req_ff, stop_req_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_gain_ff, rsp_gain_in;
   logic               rsp_changed_ff, rsp_changed_in;
   logic               rsp_playing_ff, rsp_playing_in;
   logic               rsp_stop_ff, rsp_stop_in;
   logic               rsp_silent_ff, rsp_silent_in;
   logic               rsp_start_ok_ff, rsp_start_ok_in;

   logic               req_accept;
   logic               ramp_start;
   logic               ramp_done;
   ramp_args_type      ramp_args;
   ramp_result_type    ramp_result;
   logic [MS_W-1:0]    mute_dur;

   assign req_stall  = (state_ff != T_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // Serial divide and interpolate unit for tick events.
   assign ramp_args.elapsed      = req_elapsed_ms;
   assign ramp_args.duration     = duration_ff;
   assign ramp_args.fraction     = fraction_ff;
   assign ramp_args.start_level  = start_level_ff;
   assign ramp_args.target_level = target_ff;

   vfr_ramp_step u_ramp_step (
      .clock  (clock),
      .reset  (reset),
      .start  (ramp_start),
      .args   (ramp_args),
      .done   (ramp_done),
      .result (ramp_result)
   );

   // Configuration register writes.
   always_comb begin
      menu_volume_in = menu_volume_ff;
      mute_fade_in   = mute_fade_ff;
      unmute_fade_in = unmute_fade_ff;
      start_fade_in  = start_fade_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MENU_VOLUME:    menu_volume_in = csr_wdata;
            CSR_MUTE_FADE_MS:   mute_fade_in   = csr_wdata;
            CSR_UNMUTE_FADE_MS: unmute_fade_in = csr_wdata;
            CSR_START_FADE_MS:  start_fade_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign mute_dur = req_mute_on ? mute_fade_ff : unmute_fade_ff;

   // Event handling and result capture.
   always_comb begin
      state_in        = state_ff;
      have_stream_in  = have_stream_ff;
      playing_in      = playing_ff;
      muted_in        = muted_ff;
      stopping_in     = stopping_ff;
      target_in       = target_ff;
      current_in      = current_ff;
      start_level_in  = start_level_ff;
      duration_in     = duration_ff;
      fraction_in     = fraction_ff;
      changed_in      = changed_ff;
      stop_req_in     = stop_req_ff;
      ramp_start      = 1'b0;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_gain_in     = rsp_gain_ff;
      rsp_changed_in  = rsp_changed_ff;
      rsp_playing_in  = rsp_playing_ff;
      rsp_stop_in     = rsp_stop_ff;
      rsp_silent_in   = rsp_silent_ff;
      rsp_start_ok_in = rsp_start_ok_ff;
      case (state_ff)
         T_IDLE: begin
            if (req_accept) begin
               changed_in  = 1'b0;
               stop_req_in = 1'b0;
               state_in    = T_FINISH;
               case (req_op)
                  OP_TICK: begin
                     if (have_stream_ff) begin
                        ramp_start = 1'b1;
                        state_in   = T_ARITH;
                     end
                  end
                  OP_SET_MUTE: begin
                     if (muted_ff != req_mute_on) begin
                        muted_in       = req_mute_on;
                        start_level_in = current_ff;
                        target_in      = req_mute_on ? '0 : menu_volume_ff;
                        duration_in    = mute_dur;
                        fraction_in    = (mute_dur == '0) ? FRAC_ONE : '0;
                     end
                  end
                  OP_FADE_OUT: begin
                     if (have_stream_ff) begin
                        stopping_in    = 1'b1;
                        start_level_in = current_ff;
                        target_in      = '0;
                        if (muted_ff || (current_ff == '0) || (req_fade_ms == '0)) begin
                           // Silent fade out: drop to zero and stop now.
                           duration_in = '0;
                           fraction_in = FRAC_ONE;
                           changed_in  = (current_ff != '0);
                           current_in  = '0;
                           if (playing_ff) begin
                              playing_in  = 1'b0;
                              stop_req_in = 1'b1;
                           end
                        end else begin
                           duration_in = req_fade_ms;
                           fraction_in = '0;
                        end
                     end
                  end
                  OP_START: begin
                     if (!have_stream_ff && req_load_ok) begin
                        have_stream_in = 1'b1;
                        stopping_in    = 1'b0;
                        current_in     = '0;
                        start_level_in = '0;
                        target_in      = muted_ff ? '0 : menu_volume_ff;
                        duration_in    = start_fade_ff;
                        fraction_in    = (start_fade_ff == '0) ? FRAC_ONE : '0;
                        playing_in     = 1'b1;
                        changed_in     = 1'b1;
                     end
                  end
                  OP_SHUTDOWN: begin
                     stop_req_in    = have_stream_ff && playing_ff;
                     changed_in     = (current_ff != '0);
                     have_stream_in = 1'b0;
                     playing_in     = 1'b0;
                     stopping_in    = 1'b0;
                     current_in     = '0;
                     target_in      = '0;
                     start_level_in = '0;
                     duration_in    = '0;
                     fraction_in    = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         T_ARITH: begin
            if (ramp_done) begin
               fraction_in = ramp_result.fraction;
               if (ramp_result.expired) begin
                  duration_in = '0;
               end
               if (ramp_result.gain != current_ff) begin
                  current_in = ramp_result.gain;
                  changed_in = 1'b1;
               end
               // A pending stop completes once the ramp reaches silence.
               if (stopping_ff && (ramp_result.gain == '0) && playing_ff) begin
                  playing_in  = 1'b0;
                  stop_req_in = 1'b1;
               end
               state_in = T_FINISH;
            end
         end
         T_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_gain_in     = current_ff;
               rsp_changed_in  = changed_ff;
               rsp_playing_in  = playing_ff;
               rsp_stop_in     = stop_req_ff;
               rsp_silent_in   = !playing_ff && (current_ff == '0);
               rsp_start_ok_in = have_stream_ff;
               state_in        = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // Control and stream state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= T_IDLE;
         menu_volume_ff <= RST_MENU_VOLUME;
         mute_fade_ff   <= RST_MUTE_FADE_MS;
         unmute_fade_ff <= RST_UNMUTE_FADE_MS;
         start_fade_ff  <= RST_START_FADE_MS;
         have_stream_ff <= 1'b0;
         playing_ff     <= 1'b0;
         muted_ff       <= 1'b0;
         stopping_ff    <= 1'b0;
         target_ff      <= '0;
         current_ff     <= '0;
         start_level_ff <= '0;
         duration_ff    <= '0;
         fraction_ff    <= '0;
         changed_ff     <= 1'b0;
         stop_req_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         menu_volume_ff <= menu_volume_in;
         mute_fade_ff   <= mute_fade_in;
         unmute_fade_ff <= unmute_fade_in;
         start_fade_ff  <= start_fade_in;
         have_stream_ff <= have_stream_in;
         playing_ff     <= playing_in;
         muted_ff       <= muted_in;
         stopping_ff    <= stopping_in;
         target_ff      <= target_in;
         current_ff     <= current_in;
         start_level_ff <= start_level_in;
         duration_ff    <= duration_in;
         fraction_ff    <= fraction_in;
         changed_ff     <= changed_in;
         stop_req_ff    <= stop_req_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Output beat payload.
   always_ff @(posedge clock) begin
      rsp_gain_ff     <= rsp_gain_in;
      rsp_changed_ff  <= rsp_changed_in;
      rsp_playing_ff  <= rsp_playing_in;
      rsp_stop_ff     <= rsp_stop_in;
      rsp_silent_ff   <= rsp_silent_in;
      rsp_start_ok_ff <= rsp_start_ok_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_gain         = rsp_gain_ff;
   assign rsp_gain_changed = rsp_changed_ff;
   assign rsp_playing_now  = rsp_playing_ff;
   assign rsp_stop_request = rsp_stop_ff;
   assign rsp_is_silent    = rsp_silent_ff;
   assign rsp_start_ok     = rsp_start_ok_ff;

`ifndef NO_ASSERTIONS
   // The ramp unit only reports while the controller waits for it.
   a_done_in_arith: assert property (@(posedge clock) disable iff (reset)
      ramp_done |-> (state_ff == T_ARITH))
      else $error("ramp step finished outside of the arithmetic wait");

   // An accepted event always occupies the controller in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != T_IDLE))
      else $error("controller idle right after accepting an event");

   // A stop request always leaves the stream not playing.
   a_stop_not_playing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_stop_request && rsp_playing_now))
      else $error("stop request reported while still playing");

   // Without a stream nothing can be playing.
   a_no_stream_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_start_ok) |-> !rsp_playing_now)
      else $error("playing reported without a stream");
`endif

endmodule
